/* src/worst_fit_segment_allocator_macros.svh */
// assertion macros for the worst-fit segment allocator
`ifndef WORST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define WORST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
`define WFSA_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define WFSA_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define WFSA_ASSERT_IMP(label, clk, rst_n, a, b)
`define WFSA_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

/* src/wfsa_pkg.sv */
// shared constants and codes for the worst-fit segment allocator
`timescale 1ns / 1ps
`default_nettype none
package wfsa_pkg;
  localparam int MAX_SEGS_DEF  = 16;
  localparam int ADDR_BITS_DEF = 20;
  localparam int ID_BITS_DEF   = 16;
  localparam int LIFE_BITS     = 16;
  localparam int CAP_RESET     = 1048575;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_NO_ROOM = 3'd1;
  localparam status_t ST_DUP_ID  = 3'd2;
  localparam status_t ST_UNKNOWN = 3'd3;
  localparam status_t ST_FULL    = 3'd4;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_ALLOC   = 2'd0;
  localparam mode_t MODE_FREE    = 2'd1;
  localparam mode_t MODE_COMPACT = 2'd2;
  localparam mode_t MODE_TICK    = 2'd3;
endpackage
`default_nettype wire

/* src/wfsa_hole_unit.sv */
// shared hole step: measures the gap before one boundary and advances the cursor
`timescale 1ns / 1ps
`default_nettype none
module wfsa_hole_unit #(
  parameter int ADDR_BITS = wfsa_pkg::ADDR_BITS_DEF
) (
  input  wire logic [ADDR_BITS:0]   cur,
  input  wire logic [ADDR_BITS-1:0] bnd,
  input  wire logic                 bnd_is_seg,
  input  wire logic [ADDR_BITS-1:0] seg_len,
  input  wire logic [ADDR_BITS-1:0] cap,
  input  wire logic [ADDR_BITS-1:0] big,
  input  wire logic [ADDR_BITS-1:0] big_base,
  input  wire logic [ADDR_BITS-1:0] sum,
  output logic      [ADDR_BITS:0]   cur_nxt,
  output logic      [ADDR_BITS-1:0] big_nxt,
  output logic      [ADDR_BITS-1:0] big_base_nxt,
  output logic      [ADDR_BITS-1:0] sum_nxt
);
  logic                 in_hole;
  logic [ADDR_BITS-1:0] hole_end;
  logic [ADDR_BITS-1:0] hole_size;
  logic [ADDR_BITS:0]   seg_end;

  always_comb begin
    in_hole   = ({1'b0, bnd} > cur) && (cur < {1'b0, cap});
    hole_end  = (bnd < cap) ? bnd : cap;
    hole_size = ADDR_BITS'({1'b0, hole_end} - cur);
    seg_end   = {1'b0, bnd} + {1'b0, seg_len};
    sum_nxt      = sum;
    big_nxt      = big;
    big_base_nxt = big_base;
    if (in_hole) begin
      sum_nxt = sum + hole_size;
      if (hole_size > big) begin
        big_nxt      = hole_size;
        big_base_nxt = cur[ADDR_BITS-1:0];
      end
    end
    cur_nxt = cur;
    if (bnd_is_seg && (seg_end > cur)) begin
      cur_nxt = seg_end;
    end
  end
endmodule
`default_nettype wire

/* src/worst_fit_segment_allocator.sv */
// worst-fit segment allocator top level: segment table and request sequencer
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid in_stall in_mode in_owner_id ...      | request in
//  out     | out_valid out_stall out_status ...             | result out
//  cfg     | cfg_we cfg_wdata                              | capacity write
//
// a request runs the table pass, then one or two ordered walks over the live
// segments, with a decide step for allocate between its two walks, and ends
// in an output step; compact adds one extra walk.
// the ordered walk re-selects the next-lowest base one table entry per cycle.
// rst_n is synchronous; it clears valid bits and sequencer and sets capacity to CAP_RESET.
// in_stall is high from acceptance until the result is taken; out_stall holds it.
`timescale 1ns / 1ps
`default_nettype none
`include "worst_fit_segment_allocator_macros.svh"
module worst_fit_segment_allocator #(
  parameter int MAX_SEGS  = wfsa_pkg::MAX_SEGS_DEF,
  parameter int ADDR_BITS = wfsa_pkg::ADDR_BITS_DEF,
  parameter int ID_BITS   = wfsa_pkg::ID_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [ADDR_BITS-1:0]                  cfg_wdata,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [1:0]                            in_mode,
  input  wire logic [ID_BITS-1:0]                    in_owner_id,
  input  wire logic [ADDR_BITS-1:0]                  in_seg_length,
  input  wire logic [wfsa_pkg::LIFE_BITS-1:0]        in_lifetime,
  input  wire logic [wfsa_pkg::LIFE_BITS-1:0]        in_elapsed,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [2:0]                                 out_status,
  output logic [ADDR_BITS-1:0]                       out_base_addr,
  output logic [ADDR_BITS-1:0]                       out_largest_hole,
  output logic [ADDR_BITS-1:0]                       out_free_total,
  output logic [$clog2(MAX_SEGS+1)-1:0]              out_live_count,
  output logic [$clog2(MAX_SEGS+1)-1:0]              out_expired_count
);
  localparam int IDX_BITS = $clog2(MAX_SEGS);
  localparam int CNT_BITS = $clog2(MAX_SEGS+1);
  localparam int LB       = wfsa_pkg::LIFE_BITS;
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(MAX_SEGS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PASS   = 3'd1;
  localparam logic [2:0] S_SEL    = 3'd2;
  localparam logic [2:0] S_HOLE   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  localparam logic [1:0] PH_COMPACT = 2'd0;
  localparam logic [1:0] PH_PRE     = 2'd1;
  localparam logic [1:0] PH_POST    = 2'd2;

  // segment table
  logic                 valid_r [MAX_SEGS];
  logic [ID_BITS-1:0]   owner_r [MAX_SEGS];
  logic [ADDR_BITS-1:0] base_r  [MAX_SEGS];
  logic [ADDR_BITS-1:0] len_r   [MAX_SEGS];
  logic [LB-1:0]        rem_r   [MAX_SEGS];

  logic [ADDR_BITS-1:0] cap_r;
  logic [2:0]           state_r;
  logic [1:0]           phase_r;
  logic [IDX_BITS-1:0]  idx_r;

  // latched request
  wfsa_pkg::mode_t      mode_r;
  logic [ID_BITS-1:0]   id_r;
  logic [ADDR_BITS-1:0] req_len_r;
  logic [LB-1:0]        life_r;
  logic [LB-1:0]        el_r;

  logic                 dup_r;
  logic                 hit_r;
  logic                 slot_ok_r;
  logic [IDX_BITS-1:0]  slot_r;
  logic [CNT_BITS-1:0]  live_r;
  logic [CNT_BITS-1:0]  exp_r;
  wfsa_pkg::status_t    status_r;
  logic [ADDR_BITS-1:0] res_base_r;

  // ordered walk
  logic                 have_last_r;
  logic [ADDR_BITS-1:0] last_r;
  logic                 found_r;
  logic [IDX_BITS-1:0]  best_idx_r;
  logic [ADDR_BITS-1:0] best_base_r;
  logic [ADDR_BITS-1:0] pack_r;
  logic [ADDR_BITS:0]   cur_r;
  logic [ADDR_BITS-1:0] big_r;
  logic [ADDR_BITS-1:0] big_base_r;
  logic [ADDR_BITS-1:0] sum_r;

  logic [ADDR_BITS:0]   cur_nxt;
  logic [ADDR_BITS-1:0] big_nxt;
  logic [ADDR_BITS-1:0] big_base_nxt;
  logic [ADDR_BITS-1:0] sum_nxt;
  logic [ADDR_BITS-1:0] bnd;
  logic                 in_acc;
  logic                 out_acc;
  logic                 cand;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign bnd       = found_r ? best_base_r : cap_r;
  assign cand      = valid_r[idx_r] && (!have_last_r || (base_r[idx_r] > last_r)) &&
                     (!found_r || (base_r[idx_r] < best_base_r));

  wfsa_hole_unit #(.ADDR_BITS(ADDR_BITS)) u_hole (
    .cur          (cur_r),
    .bnd          (bnd),
    .bnd_is_seg   (found_r),
    .seg_len      (len_r[best_idx_r]),
    .cap          (cap_r),
    .big          (big_r),
    .big_base     (big_base_r),
    .sum          (sum_r),
    .cur_nxt      (cur_nxt),
    .big_nxt      (big_nxt),
    .big_base_nxt (big_base_nxt),
    .sum_nxt      (sum_nxt)
  );

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r    <= in_mode;
      id_r      <= in_owner_id;
      req_len_r <= in_seg_length;
      life_r    <= in_lifetime;
      el_r      <= in_elapsed;
    end
    if (state_r == S_PASS && valid_r[idx_r] && mode_r == wfsa_pkg::MODE_TICK &&
        rem_r[idx_r] > el_r) begin
      rem_r[idx_r] <= rem_r[idx_r] - el_r;
    end
    if (state_r == S_HOLE && phase_r == PH_COMPACT && found_r) begin
      base_r[best_idx_r] <= pack_r;
    end
    if (state_r == S_DECIDE && !dup_r && live_r < CNT_BITS'(MAX_SEGS) &&
        req_len_r != '0 && req_len_r <= big_r) begin
      owner_r[slot_r] <= id_r;
      base_r[slot_r]  <= big_base_r;
      len_r[slot_r]   <= req_len_r;
      rem_r[slot_r]   <= life_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cap_r   <= ADDR_BITS'(wfsa_pkg::CAP_RESET);
      for (int k = 0; k < MAX_SEGS; k++) begin
        valid_r[k] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r    <= S_PASS;
            idx_r      <= '0;
            dup_r      <= 1'b0;
            hit_r      <= 1'b0;
            slot_ok_r  <= 1'b0;
            live_r     <= '0;
            exp_r      <= '0;
            res_base_r <= '0;
          end
        end
        S_PASS: begin
          if (valid_r[idx_r]) begin
            unique case (mode_r)
              wfsa_pkg::MODE_ALLOC: begin
                live_r <= live_r + 1'b1;
                if (owner_r[idx_r] == id_r) dup_r <= 1'b1;
              end
              wfsa_pkg::MODE_FREE: begin
                if (!hit_r && owner_r[idx_r] == id_r) begin
                  valid_r[idx_r] <= 1'b0;
                  hit_r          <= 1'b1;
                end else begin
                  live_r <= live_r + 1'b1;
                end
              end
              wfsa_pkg::MODE_COMPACT: live_r <= live_r + 1'b1;
              wfsa_pkg::MODE_TICK: begin
                if (rem_r[idx_r] <= el_r) begin
                  valid_r[idx_r] <= 1'b0;
                  exp_r          <= exp_r + 1'b1;
                end else begin
                  live_r <= live_r + 1'b1;
                end
              end
              default: ;
            endcase
          end else if (!slot_ok_r) begin
            slot_ok_r <= 1'b1;
            slot_r    <= idx_r;
          end
          if (idx_r == LAST_IDX) begin
            state_r     <= S_SEL;
            idx_r       <= '0;
            have_last_r <= 1'b0;
            found_r     <= 1'b0;
            pack_r      <= '0;
            cur_r       <= '0;
            big_r       <= '0;
            big_base_r  <= '0;
            sum_r       <= '0;
            if (mode_r == wfsa_pkg::MODE_COMPACT) phase_r <= PH_COMPACT;
            else if (mode_r == wfsa_pkg::MODE_ALLOC) phase_r <= PH_PRE;
            else phase_r <= PH_POST;
            if (mode_r == wfsa_pkg::MODE_FREE && !hit_r &&
                !(valid_r[idx_r] && owner_r[idx_r] == id_r)) begin
              status_r <= wfsa_pkg::ST_UNKNOWN;
            end else begin
              status_r <= wfsa_pkg::ST_OK;
            end
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_SEL: begin
          // keep the lowest base above the last boundary
          if (cand) begin
            found_r     <= 1'b1;
            best_idx_r  <= idx_r;
            best_base_r <= base_r[idx_r];
          end
          if (idx_r == LAST_IDX) state_r <= S_HOLE;
          idx_r <= idx_r + 1'b1;
        end
        S_HOLE: begin
          idx_r <= '0;
          if (phase_r == PH_COMPACT) begin
            if (found_r) begin
              pack_r      <= pack_r + len_r[best_idx_r];
              last_r      <= best_base_r;
              have_last_r <= 1'b1;
              found_r     <= 1'b0;
              state_r     <= S_SEL;
            end else begin
              phase_r     <= PH_POST;
              have_last_r <= 1'b0;
              state_r     <= S_SEL;
            end
          end else begin
            cur_r      <= cur_nxt;
            big_r      <= big_nxt;
            big_base_r <= big_base_nxt;
            sum_r      <= sum_nxt;
            if (found_r) begin
              last_r      <= best_base_r;
              have_last_r <= 1'b1;
              found_r     <= 1'b0;
              state_r     <= S_SEL;
            end else if (phase_r == PH_PRE) begin
              state_r <= S_DECIDE;
            end else begin
              out_largest_hole <= big_nxt;
              out_free_total   <= sum_nxt;
              state_r          <= S_OUT;
            end
          end
        end
        S_DECIDE: begin
          if (dup_r) begin
            status_r <= wfsa_pkg::ST_DUP_ID;
          end else if (live_r >= CNT_BITS'(MAX_SEGS)) begin
            status_r <= wfsa_pkg::ST_FULL;
          end else if (req_len_r == '0 || req_len_r > big_r) begin
            status_r <= wfsa_pkg::ST_NO_ROOM;
          end else begin
            valid_r[slot_r] <= 1'b1;
            res_base_r      <= big_base_r;
            live_r          <= live_r + 1'b1;
          end
          phase_r     <= PH_POST;
          have_last_r <= 1'b0;
          found_r     <= 1'b0;
          cur_r       <= '0;
          big_r       <= '0;
          big_base_r  <= '0;
          sum_r       <= '0;
          idx_r       <= '0;
          state_r     <= S_SEL;
        end
        S_OUT: begin
          if (out_acc) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_status        = status_r;
  assign out_base_addr     = res_base_r;
  assign out_live_count    = live_r;
  assign out_expired_count = exp_r;

  `WFSA_ASSERT_IMP(a_idle_no_result, clk, rst_n, state_r == S_IDLE, !out_valid)
  `WFSA_ASSERT_NEXT(a_accept_starts_pass, clk, rst_n, in_acc, state_r == S_PASS)
  `WFSA_ASSERT_IMP(a_live_bound, clk, rst_n, out_valid, live_r <= CNT_BITS'(MAX_SEGS))
  `WFSA_ASSERT_IMP(a_expired_ok, clk, rst_n, out_valid && exp_r != '0,
                   status_r == wfsa_pkg::ST_OK)
endmodule
`default_nettype wire

/* test/tb.sv */
// testbench for the worst-fit segment allocator: directed table, then random requests
`timescale 1ns / 1ps
module tb;

  localparam int NSEG = 16;
  localparam int WATCH_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    wfsa_pkg::mode_t mode;
    logic [15:0] owner;
    logic [19:0] length;
    logic [15:0] life;
    logic [15:0] elapsed;
  } request_t;

  typedef struct {
    wfsa_pkg::status_t status;
    logic [19:0] base;
    logic [19:0] largest;
    logic [19:0] free_sum;
    logic [4:0] live;
    logic [4:0] expired;
  } outcome_t;

  typedef struct {
    request_t req;
    bit typed;
    outcome_t want;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [19:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_mode = '0;
  logic [15:0] in_owner_id = '0;
  logic [19:0] in_seg_length = '0;
  logic [15:0] in_lifetime = '0;
  logic [15:0] in_elapsed = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] out_status;
  logic [19:0] out_base_addr, out_largest_hole, out_free_total;
  logic [4:0] out_live_count, out_expired_count;

  worst_fit_segment_allocator dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_owner_id(in_owner_id), .in_seg_length(in_seg_length),
    .in_lifetime(in_lifetime), .in_elapsed(in_elapsed),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_base_addr(out_base_addr), .out_largest_hole(out_largest_hole),
    .out_free_total(out_free_total), .out_live_count(out_live_count),
    .out_expired_count(out_expired_count)
  );

  always #10 clk = ~clk;

  // shadow segment table
  bit seg_valid[NSEG];
  logic [15:0] seg_owner[NSEG];
  longint seg_base[NSEG];
  longint seg_len[NSEG];
  logic [15:0] seg_life[NSEG];
  longint cap_units = wfsa_pkg::CAP_RESET;

  outcome_t pending_results[$];
  int errors = 0;
  int idle_mode = 0;   // 0: sender idles 14%, receiver 80%; 1: reversed; 2: none
  bit hold_req = 0;
  bit cur_typed = 0;
  outcome_t cur_want;

  function automatic int order_by_base(output int ord[NSEG]);
    int n, j;
    n = 0;
    for (int i = 0; i < NSEG; i++) begin
      if (seg_valid[i]) begin
        j = n;
        while (j > 0 && seg_base[ord[j-1]] > seg_base[i]) begin
          ord[j] = ord[j-1];
          j--;
        end
        ord[j] = i;
        n++;
      end
    end
    return n;
  endfunction

  function automatic void find_holes(output longint big, output longint big_at,
                                     output longint sum);
    int ord[NSEG];
    int n;
    longint cur, b, e, sz;
    n = order_by_base(ord);
    cur = 0; big = 0; big_at = 0; sum = 0;
    for (int k = 0; k <= n; k++) begin
      b = (k < n) ? seg_base[ord[k]] : cap_units;
      if (b > cur && cur < cap_units) begin
        sz = ((b < cap_units) ? b : cap_units) - cur;
        sum += sz;
        if (sz > big) begin
          big = sz;
          big_at = cur;
        end
      end
      if (k < n) begin
        e = b + seg_len[ord[k]];
        if (e > cur) cur = e;
      end
    end
  endfunction

  task automatic allocator_step(input request_t r, output outcome_t o);
    longint big, big_at, sum, x;
    int live, slot, n;
    int ord[NSEG];
    bit dup;
    o = '{status: wfsa_pkg::ST_OK, base: '0, largest: '0, free_sum: '0, live: '0,
          expired: '0};
    case (r.mode)
      wfsa_pkg::MODE_ALLOC: begin
        dup = 0; live = 0;
        for (int i = 0; i < NSEG; i++)
          if (seg_valid[i]) begin
            live++;
            if (seg_owner[i] == r.owner) dup = 1;
          end
        find_holes(big, big_at, sum);
        if (dup) o.status = wfsa_pkg::ST_DUP_ID;
        else if (live >= NSEG) o.status = wfsa_pkg::ST_FULL;
        else if (r.length == 0 || longint'(r.length) > big) o.status = wfsa_pkg::ST_NO_ROOM;
        else begin
          slot = 0;
          while (seg_valid[slot]) slot++;
          seg_valid[slot] = 1;
          seg_owner[slot] = r.owner;
          seg_base[slot] = big_at;
          seg_len[slot] = r.length;
          seg_life[slot] = r.life;
          o.base = big_at[19:0];
        end
      end
      wfsa_pkg::MODE_FREE: begin
        o.status = wfsa_pkg::ST_UNKNOWN;
        for (int i = 0; i < NSEG; i++)
          if (o.status == wfsa_pkg::ST_UNKNOWN && seg_valid[i] &&
              seg_owner[i] == r.owner) begin
            seg_valid[i] = 0;
            o.status = wfsa_pkg::ST_OK;
          end
      end
      wfsa_pkg::MODE_COMPACT: begin
        n = order_by_base(ord);
        x = 0;
        for (int k = 0; k < n; k++) begin
          seg_base[ord[k]] = x & 20'hFFFFF;
          x += seg_len[ord[k]];
        end
      end
      default: begin
        for (int i = 0; i < NSEG; i++)
          if (seg_valid[i]) begin
            if (seg_life[i] <= r.elapsed) begin
              seg_valid[i] = 0;
              o.expired++;
            end else seg_life[i] -= r.elapsed;
          end
      end
    endcase
    find_holes(big, big_at, sum);
    o.largest = big[19:0];
    o.free_sum = sum[19:0];
    for (int i = 0; i < NSEG; i++) if (seg_valid[i]) o.live++;
  endtask

  task automatic report(input string field, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // accepted requests go through the predictor
  always @(posedge clk) begin
    request_t r;
    outcome_t o;
    if (rst_n && in_valid && !in_stall) begin
      r = '{mode: in_mode, owner: in_owner_id, length: in_seg_length,
            life: in_lifetime, elapsed: in_elapsed};
      allocator_step(r, o);
      pending_results.push_back(cur_typed ? cur_want : o);
    end
  end

  // compare each delivered result with the oldest expectation
  always @(posedge clk) begin
    outcome_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        w = pending_results.pop_front();
        if (out_status !== w.status) report("status", out_status, w.status);
        if (out_base_addr !== w.base) report("base_addr", out_base_addr, w.base);
        if (out_largest_hole !== w.largest)
          report("largest_hole", out_largest_hole, w.largest);
        if (out_free_total !== w.free_sum) report("free_total", out_free_total, w.free_sum);
        if (out_live_count !== w.live) report("live_count", out_live_count, w.live);
        if (out_expired_count !== w.expired)
          report("expired_count", out_expired_count, w.expired);
      end
    end
  end

  // result side back-pressure, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      out_stall <= 1;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_req = 0;
    end else case (idle_mode)
      0: out_stall <= ($urandom_range(99) < 80);
      1: out_stall <= ($urandom_range(99) < 14);
      default: out_stall <= 0;
    endcase
  end

  // watchdog on cycles without any handshake
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send(input request_t r, input bit typed, input outcome_t want);
    int gap;
    gap = 0;
    if (idle_mode == 0 && $urandom_range(99) < 14) gap = $urandom_range(1, 6);
    if (idle_mode == 1 && $urandom_range(99) < 80) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    cur_typed = typed;
    cur_want = want;
    in_mode <= r.mode;
    in_owner_id <= r.owner;
    in_seg_length <= r.length;
    in_lifetime <= r.life;
    in_elapsed <= r.elapsed;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic set_capacity(input logic [19:0] units);
    in_valid <= 0;
    wait (pending_results.size() == 0);
    repeat (4) @(negedge clk);
    cfg_wdata <= units;
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
    cap_units = units;
  endtask

  function automatic request_t random_request();
    request_t r;
    int pick;
    longint span;
    pick = $urandom_range(99);
    r.mode = (pick < 45) ? wfsa_pkg::MODE_ALLOC : (pick < 70) ? wfsa_pkg::MODE_FREE :
             (pick < 80) ? wfsa_pkg::MODE_COMPACT : wfsa_pkg::MODE_TICK;
    r.owner = ($urandom_range(99) < 95) ? 16'($urandom_range(19)) : 16'($urandom);
    span = cap_units / 6;
    if (span < 1) span = 1;
    r.length = ($urandom_range(99) < 92) ? 20'($urandom_range(1, int'(span)))
                                         : 20'($urandom_range(1, 20'hFFFFF));
    r.life = ($urandom_range(99) < 95) ? 16'($urandom_range(1, 200)) : 16'($urandom);
    r.elapsed = ($urandom_range(99) < 95) ? 16'($urandom_range(0, 40)) : 16'($urandom);
    return r;
  endfunction

  row_t directed[$];
  localparam logic [19:0] FULL = 20'hFFFFF;

  function automatic request_t mk(wfsa_pkg::mode_t m, int id, int len, int life, int el);
    return '{mode: m, owner: 16'(id), length: 20'(len), life: 16'(life), elapsed: 16'(el)};
  endfunction

  function automatic outcome_t res(wfsa_pkg::status_t s, logic [19:0] b, logic [19:0] lg,
                                   logic [19:0] fr, int lv);
    return '{status: s, base: b, largest: lg, free_sum: fr, live: 5'(lv), expired: '0};
  endfunction

  initial begin
    request_t r;
    outcome_t none;
    int caps[6];
    caps = '{1048575, 1, 4096, 300, 65535, 1048575};
    none = '{status: wfsa_pkg::ST_OK, base: '0, largest: '0, free_sum: '0, live: '0,
             expired: '0};

    // extremes and every status code but table full, with results written out directly
    directed.push_back('{mk(wfsa_pkg::MODE_ALLOC, 0, FULL, 65535, 0), 1,
                         res(wfsa_pkg::ST_OK, 0, 0, 0, 1)});
    directed.push_back('{mk(wfsa_pkg::MODE_ALLOC, 0, 1, 1, 0), 1,
                         res(wfsa_pkg::ST_DUP_ID, 0, 0, 0, 1)});
    directed.push_back('{mk(wfsa_pkg::MODE_ALLOC, 1, 1, 1, 0), 1,
                         res(wfsa_pkg::ST_NO_ROOM, 0, 0, 0, 1)});
    directed.push_back('{mk(wfsa_pkg::MODE_FREE, 65535, 0, 0, 0), 1,
                         res(wfsa_pkg::ST_UNKNOWN, 0, 0, 0, 1)});
    directed.push_back('{mk(wfsa_pkg::MODE_FREE, 0, 0, 0, 0), 1,
                         res(wfsa_pkg::ST_OK, 0, FULL, FULL, 0)});
    // zero length is refused
    directed.push_back('{mk(wfsa_pkg::MODE_ALLOC, 65535, 0, 5, 0), 1,
                         res(wfsa_pkg::ST_NO_ROOM, 0, FULL, FULL, 0)});
    directed.push_back('{mk(wfsa_pkg::MODE_TICK, 0, 0, 0, 0), 1,
                         res(wfsa_pkg::ST_OK, 0, FULL, FULL, 0)});
    // fill the table, then one more for table full
    for (int k = 0; k < 16; k++)
      directed.push_back('{mk(wfsa_pkg::MODE_ALLOC, 100 + k, 10 + k, (k == 3) ? 0 : k + 2, 0),
                           0, none});
    directed.push_back('{mk(wfsa_pkg::MODE_ALLOC, 200, 1, 1, 0), 0, none});
    directed.push_back('{mk(wfsa_pkg::MODE_FREE, 105, 0, 0, 0), 0, none});
    directed.push_back('{mk(wfsa_pkg::MODE_COMPACT, 0, 0, 0, 0), 0, none});
    directed.push_back('{mk(wfsa_pkg::MODE_TICK, 0, 0, 0, 5), 0, none});
    directed.push_back('{mk(wfsa_pkg::MODE_TICK, 0, 0, 0, 65535), 0, none});

    repeat (12) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    foreach (directed[i]) send(directed[i].req, directed[i].typed, directed[i].want);

    for (int p = 0; p < 6; p++) begin
      idle_mode = p / 2;
      set_capacity(20'(caps[p]));
      for (int n = 0; n < 240; n++) begin
        if (p == 4 && n == 50) hold_req = 1;
        r = random_request();
        send(r, 0, none);
      end
    end
    in_valid <= 0;

    wait (pending_results.size() == 0);
    repeat (1000) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
